/* design/tkh_pkg.sv */
// shared types, constants and helpers for the triangle k-count histogram
`default_nettype none

package tkh_pkg;

  localparam int DEFAULT_MAX_BINS = 64;
  localparam int VAL_W            = 20;
  localparam int CNT_W            = 32;
  localparam int LIMIT_W          = 7;
  localparam int IDX_W            = 6;
  localparam int KVAL_W           = 6;
  localparam int K_FIRST          = 3;
  localparam int LIMIT_MIN        = 4;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  typedef enum logic [1:0] {
    StIdle,
    StCalc,
    StWrite
  } tkh_state_e;

  typedef enum logic {
    ReqCount = 1'b0,
    ReqRead  = 1'b1
  } tkh_req_e;

  // number of pairs among n items
  function automatic int tkh_pairs(input int n);
    int r;
    r = 0;
    if (n >= 2) begin
      r = (n * (n - 1)) / 2;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/tkh_bin_ram.sv */
// histogram bin memory, one write and one registered read port, per-entry valid bits
`default_nettype none

module tkh_bin_ram #(
  parameter int DEPTH = tkh_pkg::DEFAULT_MAX_BINS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     rd_en_i,
  input  wire logic [AW-1:0]            rd_addr_i,
  output logic      [tkh_pkg::CNT_W-1:0] rd_data_o,
  input  wire logic                     wr_en_i,
  input  wire logic [AW-1:0]            wr_addr_i,
  input  wire logic [tkh_pkg::CNT_W-1:0] wr_data_i
);
  import tkh_pkg::*;

  logic [CNT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [CNT_W-1:0] rd_data_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // an entry never written since reset reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

/* design/tkh_kfind.sv */
// parallel threshold compares and thermometer encode for the k bin
`default_nettype none

module tkh_kfind #(
  parameter int MAX_BINS = tkh_pkg::DEFAULT_MAX_BINS,
  parameter int AW       = $clog2(MAX_BINS),
  parameter int LW       = $clog2(MAX_BINS + 1)
) (
  input  wire logic [tkh_pkg::VAL_W-1:0] vmin_i,
  input  wire logic [tkh_pkg::VAL_W-1:0] emin_i,
  input  wire logic [LW-1:0]             lim_i,
  output logic      [AW-1:0]             best_o
);
  import tkh_pkg::*;

  logic [MAX_BINS:0] ok;

  // ok is a thermometer: once a threshold fails all larger k fail too
  always_comb begin
    ok = '0;
    for (int j = K_FIRST; j < MAX_BINS; j++) begin
      if (j == K_FIRST) begin
        ok[j] = 1'b1;
      end else begin
        ok[j] = (int'(vmin_i) >= tkh_pairs(j - 1)) && (int'(emin_i) >= j - 2) &&
                (j < int'(lim_i));
      end
    end
  end

  always_comb begin
    best_o = '0;
    for (int j = K_FIRST; j < MAX_BINS; j++) begin
      if (ok[j] && !ok[j+1]) begin
        best_o = best_o | AW'(j);
      end
    end
  end

endmodule

`default_nettype wire

/* design/triangle_kcount_histogram.sv */
// triangle k-count histogram top level: request control, k search and bin update
// flow: a request is accepted, then StCalc computes k and reads the bin, and StWrite
//   writes the bin back and loads the result register, holding while it is full
// a new request waits for StWrite to finish, due to the bin ram read-modify-write
// reset: all bins read as zero and bin_limit is 64 right after reset, no clearing pass
`default_nettype none

module triangle_kcount_histogram #(
  parameter int MAX_BINS = tkh_pkg::DEFAULT_MAX_BINS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [tkh_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         req_type_i,
  input  wire logic [tkh_pkg::VAL_W-1:0]    vert_first_i,
  input  wire logic [tkh_pkg::VAL_W-1:0]    vert_second_i,
  input  wire logic [tkh_pkg::VAL_W-1:0]    vert_third_i,
  input  wire logic [tkh_pkg::VAL_W-1:0]    vdeg_first_i,
  input  wire logic [tkh_pkg::VAL_W-1:0]    vdeg_second_i,
  input  wire logic [tkh_pkg::VAL_W-1:0]    vdeg_third_i,
  input  wire logic [tkh_pkg::VAL_W-1:0]    edeg_one_i,
  input  wire logic [tkh_pkg::VAL_W-1:0]    edeg_two_i,
  input  wire logic [tkh_pkg::VAL_W-1:0]    edeg_three_i,
  input  wire logic [tkh_pkg::IDX_W-1:0]    bin_index_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              counted_o,
  output logic      [tkh_pkg::KVAL_W-1:0]   kvalue_o,
  output logic      [tkh_pkg::CNT_W-1:0]    bin_count_o
);
  import tkh_pkg::*;

  localparam int AW = $clog2(MAX_BINS);
  localparam int LW = $clog2(MAX_BINS + 1);

  tkh_state_e state_q, state_d;

  logic [LIMIT_W-1:0] bin_limit_q;
  logic [LW-1:0]      lim;

  logic               req_rd_q;
  logic               cnt_q;
  logic [VAL_W-1:0]   vmin_q, emin_q;
  logic [VAL_W-1:0]   vmin_d, emin_d;
  logic [IDX_W-1:0]   idx_q;
  logic [AW-1:0]      best, best_q;

  logic               accept;
  logic               slot_free;
  logic               finish;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [CNT_W-1:0]   rd_data;
  logic               wr_en;
  logic [CNT_W-1:0]   wr_data;
  logic               idx_in_range;

  logic               out_valid_q;
  logic               counted_q;
  logic [KVAL_W-1:0]  kvalue_q;
  logic [CNT_W-1:0]   bin_count_q;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      bin_limit_q <= cfg_wdata_i;
    end
  end

  // clamp the limit into [4, MAX_BINS]
  always_comb begin
    if (int'(bin_limit_q) > MAX_BINS) begin
      lim = LW'(MAX_BINS);
    end else if (int'(bin_limit_q) < LIMIT_MIN) begin
      lim = LW'(LIMIT_MIN);
    end else begin
      lim = LW'(bin_limit_q);
    end
  end

  always_comb begin
    vmin_d = vdeg_first_i;
    if (vdeg_second_i < vmin_d) vmin_d = vdeg_second_i;
    if (vdeg_third_i < vmin_d)  vmin_d = vdeg_third_i;
    emin_d = edeg_one_i;
    if (edeg_two_i < emin_d)    emin_d = edeg_two_i;
    if (edeg_three_i < emin_d)  emin_d = edeg_three_i;
  end

  assign slot_free = !out_valid_q || out_ready_i;
  assign accept    = in_valid_i && in_ready_o;

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_rd_q <= (req_type_i == ReqRead);
      cnt_q    <= (req_type_i == ReqCount) && (vert_first_i > vert_second_i) &&
                  (vert_first_i > vert_third_i);
      vmin_q   <= vmin_d;
      emin_q   <= emin_d;
      idx_q    <= bin_index_i;
    end
    if (state_q == StCalc) begin
      best_q <= best;
    end
  end

  tkh_kfind #(
    .MAX_BINS (MAX_BINS),
    .AW       (AW),
    .LW       (LW)
  ) u_kfind (
    .vmin_i (vmin_q),
    .emin_i (emin_q),
    .lim_i  (lim),
    .best_o (best)
  );

  assign idx_in_range = int'(idx_q) < MAX_BINS;
  assign rd_addr      = req_rd_q ? AW'(idx_q) : best;
  assign rd_en        = (state_q == StCalc);

  // saturating increment
  assign wr_data = (rd_data == '1) ? rd_data : rd_data + CNT_W'(1);
  assign wr_en   = finish && cnt_q;

  tkh_bin_ram #(
    .DEPTH (MAX_BINS),
    .AW    (AW)
  ) u_bin_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (best_q),
    .wr_data_i (wr_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    finish     = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = StCalc;
      end
      StCalc: begin
        state_d = StWrite;
      end
      StWrite: begin
        // hold here until the result register can take the result
        if (slot_free) begin
          finish     = 1'b1;
          in_ready_o = 1'b1;
          state_d    = in_valid_i ? StCalc : StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      counted_q   <= cnt_q;
      kvalue_q    <= cnt_q ? KVAL_W'(best_q) : '0;
      bin_count_q <= (req_rd_q && idx_in_range) ? rd_data : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign counted_o   = counted_q;
  assign kvalue_o    = kvalue_q;
  assign bin_count_o = bin_count_q;

`ifndef SYNTHESIS
  a_accept_to_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == StCalc)
    else $error("accepted request did not start the k search");

  a_result_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StWrite)
    else $error("result appeared outside the write-back step");

  a_best_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StCalc |-> int'(best) < int'(lim))
    else $error("chosen bin is not below the bin limit");

  a_write_only_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> cnt_q && !req_rd_q && state_q == StWrite)
    else $error("bin written for a request that is not a counted triangle");
`endif

endmodule

`default_nettype wire

/* bench/tkh_kcount_checker.sv */
// checker for the triangle k-count histogram: shadow histogram, k search and result compare
`timescale 1ns / 100ps

module tkh_kcount_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tkh_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic                         req_type_i,
  input  logic [tkh_pkg::VAL_W-1:0]    vert_first_i,
  input  logic [tkh_pkg::VAL_W-1:0]    vert_second_i,
  input  logic [tkh_pkg::VAL_W-1:0]    vert_third_i,
  input  logic [tkh_pkg::VAL_W-1:0]    vdeg_first_i,
  input  logic [tkh_pkg::VAL_W-1:0]    vdeg_second_i,
  input  logic [tkh_pkg::VAL_W-1:0]    vdeg_third_i,
  input  logic [tkh_pkg::VAL_W-1:0]    edeg_one_i,
  input  logic [tkh_pkg::VAL_W-1:0]    edeg_two_i,
  input  logic [tkh_pkg::VAL_W-1:0]    edeg_three_i,
  input  logic [tkh_pkg::IDX_W-1:0]    bin_index_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic                         counted_i,
  input  logic [tkh_pkg::KVAL_W-1:0]   kvalue_i,
  input  logic [tkh_pkg::CNT_W-1:0]    bin_count_i,
  output int                           error_count_o,
  output int                           pending_o
);
  import tkh_pkg::*;

  localparam int NBINS = DEFAULT_MAX_BINS;

  typedef struct packed {
    logic              counted;
    logic [KVAL_W-1:0] kvalue;
    logic [CNT_W-1:0]  bin_count;
  } kcount_result_t;

  logic [CNT_W-1:0]   kcount_shadow [NBINS];
  logic [LIMIT_W-1:0] limit_shadow;
  kcount_result_t     kcount_results_q [$];

  initial begin
    error_count_o = 0;
    pending_o     = 0;
  end

  // updates the shadow histogram and returns the result the block owes
  function automatic kcount_result_t predict_kcount(
    input logic             kind,
    input logic [VAL_W-1:0] v1, v2, v3,
    input logic [VAL_W-1:0] d1, d2, d3,
    input logic [VAL_W-1:0] e1, e2, e3,
    input logic [IDX_W-1:0] idx
  );
    kcount_result_t   res;
    logic [VAL_W-1:0] vmin, emin;
    int               lim, best;
    logic             ok;
    res = '0;
    if (kind == ReqRead) begin
      if (int'(idx) < NBINS) res.bin_count = kcount_shadow[idx];
    end else if (v1 > v2 && v1 > v3) begin
      vmin = (d1 < d2) ? d1 : d2;
      if (d3 < vmin) vmin = d3;
      emin = (e1 < e2) ? e1 : e2;
      if (e3 < emin) emin = e3;
      lim = int'(limit_shadow);
      if (lim < LIMIT_MIN) lim = LIMIT_MIN;
      if (lim > NBINS) lim = NBINS;
      best = K_FIRST;
      ok   = 1'b1;
      // thresholds grow with k, so the first miss ends the climb
      for (int k = K_FIRST; k < lim; k++) begin
        ok = ok && (int'(vmin) >= (k - 1) * (k - 2) / 2) && (int'(emin) >= k - 2);
        if (ok) best = k;
      end
      if (kcount_shadow[best] != '1) kcount_shadow[best] = kcount_shadow[best] + 1;
      res.counted = 1'b1;
      res.kvalue  = best[KVAL_W-1:0];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    kcount_result_t want;
    if (!rst_ni) begin
      for (int b = 0; b < NBINS; b++) kcount_shadow[b] = '0;
      limit_shadow = LIMIT_RESET;
      kcount_results_q.delete();
    end else begin
      if (cfg_we_i) limit_shadow = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (kcount_results_q.size() == 0) begin
          $error("result with no request outstanding");
          error_count_o++;
        end else begin
          want = kcount_results_q.pop_front();
          if (counted_i !== want.counted) begin
            $error("counted: expected %0d, actual %0d", want.counted, counted_i);
            error_count_o++;
          end
          if (kvalue_i !== want.kvalue) begin
            $error("kvalue: expected %0d, actual %0d", want.kvalue, kvalue_i);
            error_count_o++;
          end
          if (bin_count_i !== want.bin_count) begin
            $error("bin_count: expected %0d, actual %0d", want.bin_count, bin_count_i);
            error_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        kcount_results_q = {kcount_results_q, predict_kcount(req_type_i,
          vert_first_i, vert_second_i, vert_third_i,
          vdeg_first_i, vdeg_second_i, vdeg_third_i,
          edeg_one_i, edeg_two_i, edeg_three_i, bin_index_i)};
      end
    end
    pending_o <= kcount_results_q.size();
  end

endmodule

/* bench/triangle_kcount_histogram_tb.sv */
// testbench top for the triangle k-count histogram: clock, reset, requests and verdict
`timescale 1ns / 100ps

module triangle_kcount_histogram_tb;
  import tkh_pkg::*;

  localparam int STUCK_LIMIT = 500;

  typedef struct packed {
    tkh_req_e         kind;
    logic [VAL_W-1:0] vert_first;
    logic [VAL_W-1:0] vert_second;
    logic [VAL_W-1:0] vert_third;
    logic [VAL_W-1:0] vdeg_first;
    logic [VAL_W-1:0] vdeg_second;
    logic [VAL_W-1:0] vdeg_third;
    logic [VAL_W-1:0] edeg_one;
    logic [VAL_W-1:0] edeg_two;
    logic [VAL_W-1:0] edeg_three;
    logic [IDX_W-1:0] bin_index;
  } tri_req_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  tri_req_t           req_q;
  logic               out_valid;
  logic               out_ready;
  logic               counted;
  logic [KVAL_W-1:0]  kvalue;
  logic [CNT_W-1:0]   bin_count;
  int                 errors;
  int                 pending;
  int                 stuck_cycles;
  bit                 calm;

  triangle_kcount_histogram i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .req_type_i   (req_q.kind),
    .vert_first_i (req_q.vert_first),
    .vert_second_i(req_q.vert_second),
    .vert_third_i (req_q.vert_third),
    .vdeg_first_i (req_q.vdeg_first),
    .vdeg_second_i(req_q.vdeg_second),
    .vdeg_third_i (req_q.vdeg_third),
    .edeg_one_i   (req_q.edeg_one),
    .edeg_two_i   (req_q.edeg_two),
    .edeg_three_i (req_q.edeg_three),
    .bin_index_i  (req_q.bin_index),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .counted_o    (counted),
    .kvalue_o     (kvalue),
    .bin_count_o  (bin_count)
  );

  tkh_kcount_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .req_type_i   (req_q.kind),
    .vert_first_i (req_q.vert_first),
    .vert_second_i(req_q.vert_second),
    .vert_third_i (req_q.vert_third),
    .vdeg_first_i (req_q.vdeg_first),
    .vdeg_second_i(req_q.vdeg_second),
    .vdeg_third_i (req_q.vdeg_third),
    .edeg_one_i   (req_q.edeg_one),
    .edeg_two_i   (req_q.edeg_two),
    .edeg_three_i (req_q.edeg_three),
    .bin_index_i  (req_q.bin_index),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .counted_i    (counted),
    .kvalue_i     (kvalue),
    .bin_count_i  (bin_count),
    .error_count_o(errors),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // cycles with no request and no result moving
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // result side stalls in short bursts
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(5, 0) == 0) begin
        stall_left = $urandom_range(3, 0);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic int tri_pairs(input int n);
    return (n < 2) ? 0 : n * (n - 1) / 2;
  endfunction

  function automatic tri_req_t bin_read(input int idx);
    tri_req_t r;
    r           = '0;
    r.kind      = ReqRead;
    r.bin_index = idx[IDX_W-1:0];
    return r;
  endfunction

  function automatic tri_req_t tri_fixed(
    input logic [VAL_W-1:0] v1, v2, v3, d1, d2, d3, e1, e2, e3
  );
    tri_req_t r;
    r             = '0;
    r.kind        = ReqCount;
    r.vert_first  = v1;
    r.vert_second = v2;
    r.vert_third  = v3;
    r.vdeg_first  = d1;
    r.vdeg_second = d2;
    r.vdeg_third  = d3;
    r.edeg_one    = e1;
    r.edeg_two    = e2;
    r.edeg_three  = e3;
    r.bin_index   = '1;
    return r;
  endfunction

  // counted triangle whose degrees sit near the thresholds of k_goal
  function automatic tri_req_t triangle_with_k(input int k_goal);
    tri_req_t         r;
    logic [VAL_W-1:0] vmin, emin;
    r             = '0;
    r.kind        = ReqCount;
    r.bin_index   = IDX_W'($urandom);
    r.vert_first  = VAL_W'($urandom_range(20'hFFFFF, 1));
    r.vert_second = VAL_W'($urandom_range(r.vert_first - 1, 0));
    r.vert_third  = VAL_W'($urandom_range(r.vert_first - 1, 0));
    vmin = VAL_W'(tri_pairs(k_goal - 1) + int'($urandom_range(k_goal - 1, 0)));
    emin = VAL_W'(k_goal - 2 + int'($urandom_range(1, 0)));
    // sometimes only one of the two minima limits k
    if ($urandom_range(7, 0) == 0) vmin = VAL_W'($urandom_range(20'hFFFFF, vmin));
    if ($urandom_range(7, 0) == 0) emin = VAL_W'($urandom_range(20'hFFFFF, emin));
    r.vdeg_first  = VAL_W'($urandom_range(20'hFFFFF, vmin));
    r.vdeg_second = VAL_W'($urandom_range(20'hFFFFF, vmin));
    r.vdeg_third  = VAL_W'($urandom_range(20'hFFFFF, vmin));
    r.edeg_one    = VAL_W'($urandom_range(20'hFFFFF, emin));
    r.edeg_two    = VAL_W'($urandom_range(20'hFFFFF, emin));
    r.edeg_three  = VAL_W'($urandom_range(20'hFFFFF, emin));
    case ($urandom_range(2, 0))
      0: r.vdeg_first = vmin;
      1: r.vdeg_second = vmin;
      default: r.vdeg_third = vmin;
    endcase
    case ($urandom_range(2, 0))
      0: r.edeg_one = emin;
      1: r.edeg_two = emin;
      default: r.edeg_three = emin;
    endcase
    return r;
  endfunction

  function automatic tri_req_t random_request();
    tri_req_t         r;
    int               pick, goal;
    logic [VAL_W-1:0] held;
    pick = $urandom_range(99, 0);
    goal = ($urandom_range(1, 0) == 0) ? $urandom_range(66, 2) : $urandom_range(8, 2);
    r    = triangle_with_k(goal);
    if (pick < 20) begin
      r = bin_read($urandom_range(63, 0));
    end else if (pick < 30) begin
      r.vert_first  = VAL_W'($urandom);
      r.vert_second = VAL_W'($urandom);
      r.vert_third  = VAL_W'($urandom);
      r.vdeg_first  = VAL_W'($urandom);
      r.vdeg_second = VAL_W'($urandom);
      r.vdeg_third  = VAL_W'($urandom);
      r.edeg_one    = VAL_W'($urandom);
      r.edeg_two    = VAL_W'($urandom);
      r.edeg_three  = VAL_W'($urandom);
    end else if (pick < 40) begin
      // first id not strictly the largest
      case ($urandom_range(2, 0))
        0: r.vert_first = r.vert_second;
        1: r.vert_first = r.vert_third;
        default: begin
          held          = r.vert_first;
          r.vert_first  = r.vert_second;
          r.vert_second = held;
        end
      endcase
    end
    return r;
  endfunction

  // call at a falling edge; returns at the falling edge after the request is taken
  task automatic send_request(input tri_req_t r);
    if (!calm && $urandom_range(4, 0) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    req_q    <= r;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (3) @(negedge clk_i);
  endtask

  initial begin
    logic [LIMIT_W-1:0] lim_val;
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    req_q     = '0;
    calm      = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // fresh histogram reads zero
    send_request(bin_read(0));
    send_request(bin_read(63));
    // zero degrees still land in bin 3
    send_request(tri_fixed(20'd1, 20'd0, 20'd0, '0, '0, '0, '0, '0, '0));
    // all ones climbs to the top bin in use
    send_request(tri_fixed(20'hFFFFF, 20'hFFFFE, 20'd0, '1, '1, '1, '1, '1, '1));
    // first id ties or trails: not counted
    send_request(tri_fixed(20'hFFFFF, 20'hFFFFF, 20'd0, '1, '1, '1, '1, '1, '1));
    send_request(tri_fixed(20'd5, 20'd3, 20'd5, 20'd9, 20'd9, 20'd9, 20'd9, 20'd9, 20'd9));
    send_request(tri_fixed(20'd2, 20'd7, 20'd1, 20'd9, 20'd9, 20'd9, 20'd9, 20'd9, 20'd9));
    send_request(tri_fixed('1, '1, '1, '1, '1, '1, '1, '1, '1));
    // thresholds around k = 10: vmin 36, emin 8
    send_request(tri_fixed(20'd9, 20'd8, 20'd7, 20'd36, 20'd50, 20'd40, 20'd8, 20'd9, 20'd8));
    send_request(tri_fixed(20'd9, 20'd8, 20'd7, 20'd50, 20'd35, 20'd40, 20'd9, 20'd8, 20'd9));
    send_request(tri_fixed(20'd9, 20'd8, 20'd7, 20'd50, 20'd40, 20'd36, 20'd9, 20'd9, 20'd7));
    send_request(tri_fixed(20'd9, 20'd8, 20'd7, 20'd45, 20'd45, 20'd45, 20'd8, 20'd8, 20'd8));
    send_request(tri_fixed(20'd9, 20'd8, 20'd7, 20'd45, 20'd45, 20'd45, 20'd9, 20'd9, 20'd9));
    send_request(tri_fixed(20'hFFFFF, 20'd1, 20'hFFFFE, 20'd3, '1, '1, '1, 20'd2, '1));
    send_request(bin_read(3));
    send_request(bin_read(9));
    send_request(bin_read(10));
    send_request(bin_read(11));
    send_request(bin_read(4));
    send_request(bin_read(63));

    for (int phase = 0; phase < 12; phase++) begin
      drain_requests();
      case (phase)
        0: lim_val = 7'd4;
        1: lim_val = 7'd0;
        2: lim_val = 7'd3;
        3: lim_val = 7'd127;
        4: lim_val = 7'd65;
        5: lim_val = 7'd1;
        6: lim_val = 7'd5;
        7: lim_val = 7'd100;
        11: lim_val = 7'd64;
        default: lim_val = LIMIT_W'($urandom_range(63, 6));
      endcase
      cfg_we    <= 1'b1;
      cfg_wdata <= lim_val;
      @(negedge clk_i);
      cfg_we <= 1'b0;
      calm = (phase == 11);
      repeat (70) send_request(random_request());
    end

    drain_requests();
    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
